/* rtl/assert_macros.svh */
// assertion macros used by the dedup fifo rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition must hold at every clock edge outside reset
`define DPF_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dpf check failed");

// trigger in one cycle implies result in the next
`define DPF_ASSERT_NEXT(lbl, clk, rst_n, trig, res) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) \
        else $error("dpf sequence check failed");

`else

`define DPF_ASSERT(lbl, clk, rst_n, cond)
`define DPF_ASSERT_NEXT(lbl, clk, rst_n, trig, res)

`endif

`endif

/* rtl/dpf_pkg.sv */
package dpf_pkg;

    // number of cells in the chain
    localparam int DEPTH = 64;

    // widths that follow from the depth
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    // fixed field widths
    localparam int LIM_W = 7;
    localparam int CNT_W = 7;
    localparam int EXT_W = (OCC_W > LIM_W) ? OCC_W : LIM_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // opcodes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_FWD   = 2'd1;
    localparam logic [1:0] OP_COUNT = 2'd2;

    // one packet record
    typedef struct packed {
        logic [15:0] src;
        logic [15:0] dst;
        logic [31:0] ts;
    } rec_t;

    // one cell's content
    typedef struct packed {
        logic valid;
        rec_t rec;
    } entry_t;

    // per-cell control
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

endpackage

/* rtl/dedup_packet_fifo_with_range_count.sv */
// channel   | ports                                              | transfer at
// ----------+----------------------------------------------------+---------------------
// command   | start, busy, opcode, source, destination,          | start & !busy
//           | timestamp, start_time, end_time                    |
// result    | done, accepted, out_source, out_destination,       | every cycle with done
//           | out_timestamp, match_count                         |
// config    | cfg_we, cfg_wdata (capacity_limit)                 | cfg_we
//
// records sit in a chain of DEPTH cells, oldest in cell 0, packed toward cell 0.
// add and count rotate the whole chain once past cell 0 in the scan state, then pass
// through the finish state; done is registered at the finish edge.
// forward and the unused opcode finish at the transfer edge; done follows next cycle.
// reset clears all valid flags, the occupancy, the sequencer and sets the limit to 64.
// results cannot be stalled; busy stays high from transfer until the finish edge.
`include "assert_macros.svh"

module dedup_packet_fifo_with_range_count (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] source,
    input  logic [15:0] destination,
    input  logic [31:0] timestamp,
    input  logic [31:0] start_time,
    input  logic [31:0] end_time,
    output logic        done,
    output logic        accepted,
    output logic [15:0] out_source,
    output logic [15:0] out_destination,
    output logic [31:0] out_timestamp,
    output logic [dpf_pkg::CNT_W-1:0] match_count,
    input  logic        cfg_we,
    input  logic [dpf_pkg::LIM_W-1:0] cfg_wdata
);

    dpf_pkg::state_t                state_reg, state_next;
    logic [1:0]                     op_reg, op_next;
    dpf_pkg::rec_t                  qry_reg, qry_next;
    logic [31:0]                    lo_reg, lo_next;
    logic [31:0]                    hi_reg, hi_next;
    logic [dpf_pkg::IDX_W-1:0]      scan_reg, scan_next;
    logic                           hit_reg, hit_next;
    logic [dpf_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [dpf_pkg::OCC_W-1:0]      occ_reg, occ_next;
    logic [dpf_pkg::LIM_W-1:0]      limit_reg;
    logic                           done_reg, done_next;
    logic                           acc_reg, acc_next;
    dpf_pkg::rec_t                  res_reg, res_next;
    logic [dpf_pkg::CNT_W-1:0]      mc_reg, mc_next;

    dpf_pkg::entry_t                cell_q  [dpf_pkg::DEPTH];
    dpf_pkg::entry_t                cell_nb [dpf_pkg::DEPTH];
    dpf_pkg::cell_ctrl_t            cell_ctrl [dpf_pkg::DEPTH];

    logic                           accept;
    logic                           shift;
    logic                           rotate;
    logic                           load_en;
    logic [dpf_pkg::IDX_W-1:0]      wr_idx;
    logic [dpf_pkg::EXT_W-1:0]      eff_limit;
    logic                           at_limit;
    logic                           dup_hit;
    logic                           win_hit;

    assign busy   = (state_reg != dpf_pkg::ST_IDLE);
    assign accept = start && !busy;

    // effective limit: zero acts as one, above depth acts as depth
    always_comb
    begin
        if (limit_reg == '0)
        begin
            eff_limit = dpf_pkg::EXT_W'(1);
        end
        else if (dpf_pkg::EXT_W'(limit_reg) > dpf_pkg::EXT_W'(dpf_pkg::DEPTH))
        begin
            eff_limit = dpf_pkg::EXT_W'(dpf_pkg::DEPTH);
        end
        else
        begin
            eff_limit = dpf_pkg::EXT_W'(limit_reg);
        end
    end

    assign at_limit = (dpf_pkg::EXT_W'(occ_reg) >= eff_limit) && (occ_reg != '0);

    // compare the entry passing cell 0 against the query
    assign dup_hit = cell_q[0].valid && (cell_q[0].rec == qry_reg);
    assign win_hit = cell_q[0].valid && (cell_q[0].rec.dst == qry_reg.dst)
                     && (cell_q[0].rec.ts >= lo_reg) && (cell_q[0].rec.ts <= hi_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        qry_next   = qry_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        scan_next  = scan_reg;
        hit_next   = hit_reg;
        cnt_next   = cnt_reg;
        occ_next   = occ_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        res_next   = res_reg;
        mc_next    = mc_reg;
        shift      = 1'b0;
        rotate     = 1'b0;
        load_en    = 1'b0;
        wr_idx     = '0;
        case (state_reg)
            dpf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = opcode;
                    qry_next.src = source;
                    qry_next.dst = destination;
                    qry_next.ts  = timestamp;
                    lo_next      = start_time;
                    hi_next      = end_time;
                    scan_next    = '0;
                    hit_next     = 1'b0;
                    cnt_next     = '0;
                    case (opcode)
                        dpf_pkg::OP_ADD, dpf_pkg::OP_COUNT:
                        begin
                            state_next = dpf_pkg::ST_SCAN;
                        end
                        dpf_pkg::OP_FWD:
                        begin
                            // pop the oldest record from cell 0
                            done_next = 1'b1;
                            mc_next   = '0;
                            if (occ_reg != '0)
                            begin
                                shift    = 1'b1;
                                occ_next = occ_reg - 1'b1;
                                acc_next = 1'b1;
                                res_next = cell_q[0].rec;
                            end
                            else
                            begin
                                acc_next = 1'b0;
                                res_next = '0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            acc_next  = 1'b0;
                            res_next  = '0;
                            mc_next   = '0;
                        end
                    endcase
                end
            end
            dpf_pkg::ST_SCAN:
            begin
                // rotate the chain one place and check cell 0
                shift     = 1'b1;
                rotate    = 1'b1;
                hit_next  = hit_reg || dup_hit;
                if (win_hit && (cnt_reg != dpf_pkg::CNT_MAX))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == dpf_pkg::IDX_W'(dpf_pkg::DEPTH - 1))
                begin
                    state_next = dpf_pkg::ST_FINISH;
                end
            end
            dpf_pkg::ST_FINISH:
            begin
                state_next = dpf_pkg::ST_IDLE;
                done_next  = 1'b1;
                res_next   = '0;
                acc_next   = 1'b0;
                mc_next    = '0;
                if (op_reg == dpf_pkg::OP_ADD)
                begin
                    if (!hit_reg)
                    begin
                        acc_next = 1'b1;
                        load_en  = 1'b1;
                        if (at_limit)
                        begin
                            // drop the oldest and append behind the rest
                            shift  = 1'b1;
                            wr_idx = dpf_pkg::IDX_W'(occ_reg - 1'b1);
                        end
                        else
                        begin
                            wr_idx   = dpf_pkg::IDX_W'(occ_reg);
                            occ_next = occ_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    mc_next = cnt_reg;
                end
            end
            default:
            begin
                state_next = dpf_pkg::ST_IDLE;
            end
        endcase
    end

    // chain of cells, cell 0 holds the oldest record
    genvar gi;
    generate
        for (gi = 0; gi < dpf_pkg::DEPTH; gi++)
        begin : g_cell
            if (gi == dpf_pkg::DEPTH - 1)
            begin : g_last
                assign cell_nb[gi] = rotate ? cell_q[0] : '0;
            end
            else
            begin : g_mid
                assign cell_nb[gi] = cell_q[gi + 1];
            end

            assign cell_ctrl[gi].shift = shift;
            assign cell_ctrl[gi].load  = load_en && (wr_idx == dpf_pkg::IDX_W'(gi));

            dpf_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl[gi]),
                .nb_in    (cell_nb[gi]),
                .load_rec (qry_reg),
                .q        (cell_q[gi])
            );
        end
    endgenerate

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dpf_pkg::ST_IDLE;
            occ_reg   <= '0;
            limit_reg <= dpf_pkg::LIM_W'(64);
            done_reg  <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
            scan_reg  <= scan_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // query and result payload
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        qry_reg <= qry_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        hit_reg <= hit_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
        mc_reg  <= mc_next;
    end

    assign done            = done_reg;
    assign accepted        = acc_reg;
    assign out_source      = res_reg.src;
    assign out_destination = res_reg.dst;
    assign out_timestamp   = res_reg.ts;
    assign match_count     = mc_reg;

    // checks
    `DPF_ASSERT(a_occ_bound, clk, rst_n, occ_reg <= dpf_pkg::OCC_W'(dpf_pkg::DEPTH))
    `DPF_ASSERT(a_head_valid, clk, rst_n, (state_reg != dpf_pkg::ST_IDLE) || (cell_q[0].valid == (occ_reg != '0)))
    `DPF_ASSERT_NEXT(a_finish_done, clk, rst_n, state_reg == dpf_pkg::ST_FINISH, done && !busy)
    `DPF_ASSERT_NEXT(a_scan_start, clk, rst_n, accept && ((opcode == dpf_pkg::OP_ADD) || (opcode == dpf_pkg::OP_COUNT)), (state_reg == dpf_pkg::ST_SCAN) && !done)

endmodule

/* rtl/dpf_cell.sv */
module dpf_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  dpf_pkg::cell_ctrl_t ctrl,
    input  dpf_pkg::entry_t     nb_in,
    input  dpf_pkg::rec_t       load_rec,
    output dpf_pkg::entry_t     q
);

    logic          valid_reg;
    logic          valid_next;
    dpf_pkg::rec_t rec_reg;
    dpf_pkg::rec_t rec_next;

    // load a new record, take the neighbor's entry, or hold
    always_comb
    begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (ctrl.load)
        begin
            valid_next = 1'b1;
            rec_next   = load_rec;
        end
        else if (ctrl.shift)
        begin
            valid_next = nb_in.valid;
            rec_next   = nb_in.rec;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign q.valid = valid_reg;
    assign q.rec   = rec_reg;

endmodule
